// ----- design/kst_pkg.sv -----
// Shared types and constants for the keyed semaphore table.
package kst_pkg;

    localparam int NUM_SLOTS = 32;
    localparam int SLOT_AW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int KEY_W     = 31;
    localparam int VAL_W     = 16;

    localparam logic [2:0] CMD_OPEN  = 3'd0;
    localparam logic [2:0] CMD_CLOSE = 3'd1;
    localparam logic [2:0] CMD_FREE  = 3'd2;
    localparam logic [2:0] CMD_INC   = 3'd3;
    localparam logic [2:0] CMD_DEC   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_BLOCK    = 2'd3;

    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    typedef struct packed {
        logic [2:0]       command;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] init_count;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [VAL_W-1:0] current_value;
    } resp_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] current;
        logic [VAL_W-1:0] maximum;
        logic [VAL_W-1:0] references;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- design/kst_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module kst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/keyed_semaphore_table_core.sv -----
// An accepted request scans every slot, reading one slot per cycle from the slot RAM,
// then executes, and the done strobe follows; key 0 or an unknown command skips the scan.
// A new request may start in the cycle that done is shown, but not before: the block is busy
// until then, so requests are handled one at a time. The result is shown for one cycle.
// Reset clears the per-slot valid flags, so the table reads as empty at once with no
// clearing pass; done and busy are low after reset.
module keyed_semaphore_table_core
    import kst_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  req_t  request,
    output logic  done,
    output resp_t result
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    localparam logic [SLOT_AW-1:0] LAST_SLOT = SLOT_AW'(NUM_SLOTS - 1);

    logic [1:0]           state_reg, state_next;
    logic [SLOT_AW-1:0]   idx_reg, idx_next;
    req_t                 req_reg, req_next;
    logic                 bad_reg, bad_next;
    logic                 found_reg, found_next;
    logic [SLOT_AW-1:0]   hit_idx_reg, hit_idx_next;
    entry_t               hit_reg, hit_next;
    logic                 free_found_reg, free_found_next;
    logic [SLOT_AW-1:0]   free_idx_reg, free_idx_next;
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic                 done_reg, done_next;
    resp_t                result_reg, result_next;

    logic                 ram_we, ram_re;
    logic [SLOT_AW-1:0]   ram_waddr, ram_raddr;
    entry_t               ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    entry_t               scan_entry;
    logic                 accept;

    kst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign accept = start && !busy;

    // A slot never written since reset reads as free.
    assign scan_entry = valid_reg[idx_reg] ? entry_t'(ram_rdata) : '0;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        req_next        = req_reg;
        bad_next        = bad_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_next        = hit_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        ram_we          = 1'b0;
        ram_waddr       = hit_idx_reg;
        ram_wdata       = hit_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next        = request;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    idx_next        = '0;
                    bad_next        = (request.key == '0) || (request.command > CMD_DEC);
                    if ((request.key == '0) || (request.command > CMD_DEC))
                    begin
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Key is nonzero here, so a match is never a free slot.
                if (!found_reg && (scan_entry.key == req_reg.key))
                begin
                    found_next   = 1'b1;
                    hit_idx_next = idx_reg;
                    hit_next     = scan_entry;
                end
                if (!free_found_reg && (scan_entry.key == '0))
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                if (idx_reg == LAST_SLOT)
                begin
                    state_next = S_EXEC;
                end
                else
                begin
                    idx_next  = idx_reg + 1'b1;
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg + 1'b1;
                end
            end

            S_EXEC:
            begin
                done_next                 = 1'b1;
                state_next                = S_IDLE;
                result_next.status        = ST_NOTFOUND;
                result_next.current_value = '0;
                ram_wdata                 = hit_reg;
                ram_waddr                 = hit_idx_reg;
                if (!bad_reg)
                begin
                    unique case (req_reg.command)
                        CMD_OPEN:
                        begin
                            if (found_reg)
                            begin
                                if (hit_reg.references != VAL_MAX)
                                begin
                                    ram_wdata.references = hit_reg.references + 1'b1;
                                end
                                ram_we                    = 1'b1;
                                result_next.status        = ST_OK;
                                result_next.current_value = hit_reg.current;
                            end
                            else if (free_found_reg)
                            begin
                                ram_waddr                 = free_idx_reg;
                                ram_wdata.key             = req_reg.key;
                                ram_wdata.current         = req_reg.init_count;
                                ram_wdata.maximum         = req_reg.init_count;
                                ram_wdata.references      = VAL_W'(1);
                                ram_we                    = 1'b1;
                                valid_next[free_idx_reg]  = 1'b1;
                                result_next.status        = ST_OK;
                                result_next.current_value = req_reg.init_count;
                            end
                            else
                            begin
                                result_next.status = ST_FULL;
                            end
                        end
                        CMD_CLOSE:
                        begin
                            if (found_reg && (hit_reg.references != '0))
                            begin
                                ram_wdata.references      = hit_reg.references - 1'b1;
                                ram_we                    = 1'b1;
                                result_next.status        = ST_OK;
                                result_next.current_value = hit_reg.current;
                            end
                        end
                        CMD_FREE:
                        begin
                            if (found_reg)
                            begin
                                ram_we             = 1'b1;
                                result_next.status = ST_OK;
                                // Releasing: the last reference goes, or none was held.
                                if (hit_reg.references <= VAL_W'(1))
                                begin
                                    ram_wdata = '0;
                                end
                                else
                                begin
                                    ram_wdata.references      = hit_reg.references - 1'b1;
                                    result_next.current_value = hit_reg.current;
                                end
                            end
                        end
                        CMD_INC:
                        begin
                            if (found_reg)
                            begin
                                ram_we             = 1'b1;
                                result_next.status = ST_OK;
                                if (hit_reg.current < hit_reg.maximum)
                                begin
                                    ram_wdata.current         = hit_reg.current + 1'b1;
                                    result_next.current_value = hit_reg.current + 1'b1;
                                end
                                else
                                begin
                                    result_next.current_value = hit_reg.current;
                                end
                            end
                        end
                        CMD_DEC:
                        begin
                            if (found_reg)
                            begin
                                if (hit_reg.current != '0)
                                begin
                                    ram_we                    = 1'b1;
                                    ram_wdata.current         = hit_reg.current - 1'b1;
                                    result_next.status        = ST_OK;
                                    result_next.current_value = hit_reg.current - 1'b1;
                                end
                                else
                                begin
                                    result_next.status = ST_BLOCK;
                                end
                            end
                        end
                        default:
                        begin
                            result_next.status = ST_NOTFOUND;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        req_reg        <= req_next;
        bad_reg        <= bad_next;
        found_reg      <= found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_reg        <= hit_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        result_reg     <= result_next;
    end

endmodule

// ----- design/kst_checker.sv -----
// Port-level checks for the keyed semaphore table, bound to the top level.
module kst_checker
    import kst_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  start,
    input logic  busy,
    input req_t  request,
    input logic  done,
    input resp_t result
);

    // An accepted request keeps the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // The strobe is shown only once the block is free again.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done shown while busy");

    // Every request that finishes gives its result as busy drops.
    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // A result is shown for exactly one cycle.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held longer than one cycle");

    // A failing request never reports a value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ST_OK)) |-> (result.current_value == '0))
        else $error("nonzero value with a failing status");

endmodule

bind keyed_semaphore_table_core kst_checker u_kst_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);

// ----- verif/tb_keyed_semaphore_table_core.sv -----
// Self-checking testbench for the keyed semaphore table core: directed and random requests.
`timescale 1ns / 1ps

module tb_keyed_semaphore_table_core;
    import kst_pkg::*;

    localparam logic [2:0] CMD_RSVD_A = 3'd5;
    localparam logic [2:0] CMD_RSVD_B = 3'd6;
    localparam logic [2:0] CMD_RSVD_C = 3'd7;
    localparam int POOL_SIZE   = 40;
    localparam int CYCLE_LIMIT = 500000;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    req_t  request = '0;
    logic  done;
    resp_t result;

    keyed_semaphore_table_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always #5 clk = ~clk;

    // Shadow copy of the semaphore table.
    logic [KEY_W-1:0] sem_key  [NUM_SLOTS];
    logic [VAL_W-1:0] sem_cur  [NUM_SLOTS];
    logic [VAL_W-1:0] sem_max  [NUM_SLOTS];
    logic [VAL_W-1:0] sem_refs [NUM_SLOTS];

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    req_t  queued_requests [$];
    resp_t expected_replies [$];

    int sent_count  = 0;
    int taken_count = 0;
    int idle_left   = 0;
    int calm_left   = 0;
    int fail_count  = 0;
    int cycle_count = 0;
    int status_tally [4] = '{0, 0, 0, 0};

    function automatic resp_t apply_semaphore_op(req_t r);
        resp_t rsp;
        int    hit;
        int    spare;
        rsp.status        = ST_NOTFOUND;
        rsp.current_value = '0;
        hit   = -1;
        spare = -1;
        if (r.key == '0 || r.command > CMD_DEC)
            return rsp;
        // Walk downward so the lowest matching and lowest free slots win.
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (sem_key[i] == r.key)
                hit = i;
            if (sem_key[i] == '0)
                spare = i;
        end
        if (r.command == CMD_OPEN)
        begin
            if (hit >= 0)
            begin
                if (sem_refs[hit] != VAL_MAX)
                    sem_refs[hit] = sem_refs[hit] + 1'b1;
                rsp.status        = ST_OK;
                rsp.current_value = sem_cur[hit];
            end
            else if (spare >= 0)
            begin
                sem_key[spare]    = r.key;
                sem_cur[spare]    = r.init_count;
                sem_max[spare]    = r.init_count;
                sem_refs[spare]   = VAL_W'(1);
                rsp.status        = ST_OK;
                rsp.current_value = r.init_count;
            end
            else
            begin
                rsp.status = ST_FULL;
            end
        end
        else if (hit >= 0)
        begin
            case (r.command)
                CMD_CLOSE:
                begin
                    if (sem_refs[hit] != '0)
                    begin
                        sem_refs[hit]     = sem_refs[hit] - 1'b1;
                        rsp.status        = ST_OK;
                        rsp.current_value = sem_cur[hit];
                    end
                end
                CMD_FREE:
                begin
                    if (sem_refs[hit] != '0)
                        sem_refs[hit] = sem_refs[hit] - 1'b1;
                    rsp.status = ST_OK;
                    if (sem_refs[hit] == '0)
                    begin
                        sem_key[hit] = '0;
                        sem_cur[hit] = '0;
                        sem_max[hit] = '0;
                    end
                    else
                    begin
                        rsp.current_value = sem_cur[hit];
                    end
                end
                CMD_INC:
                begin
                    if (sem_cur[hit] < sem_max[hit])
                        sem_cur[hit] = sem_cur[hit] + 1'b1;
                    rsp.status        = ST_OK;
                    rsp.current_value = sem_cur[hit];
                end
                default:
                begin
                    if (sem_cur[hit] != '0)
                    begin
                        sem_cur[hit]      = sem_cur[hit] - 1'b1;
                        rsp.status        = ST_OK;
                        rsp.current_value = sem_cur[hit];
                    end
                    else
                    begin
                        rsp.status = ST_BLOCK;
                    end
                end
            endcase
        end
        return rsp;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a run with none at all.
    function automatic int draw_gap();
        int roll;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 4)
        begin
            calm_left = $urandom_range(20, 40);
            return 0;
        end
        if (roll < 45)
            return 0;
        if (roll < 82)
            return $urandom_range(1, 4);
        if (roll < 95)
            return $urandom_range(5, 40);
        return $urandom_range(41, 120);
    endfunction

    task automatic push_request(logic [2:0] cmd, logic [KEY_W-1:0] k, logic [VAL_W-1:0] iv);
        req_t r;
        r.command    = cmd;
        r.key        = k;
        r.init_count = iv;
        queued_requests.push_back(r);
    endtask

    task automatic queue_random_request(int open_w, int free_w);
        logic [2:0]       cmd;
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] iv;
        int               roll;
        int               pick;
        roll = $urandom_range(99);
        if ($urandom_range(9) == 0)
            k = KEY_W'($urandom());
        else
            k = key_pool[$urandom_range(POOL_SIZE - 1)];
        if (roll < 3)
        begin
            cmd = 3'($urandom_range(7));
            k   = '0;
        end
        else if (roll < 6)
        begin
            case ($urandom_range(2))
                0:       cmd = CMD_RSVD_A;
                1:       cmd = CMD_RSVD_B;
                default: cmd = CMD_RSVD_C;
            endcase
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < open_w)
                cmd = CMD_OPEN;
            else if (pick < open_w + free_w)
                cmd = CMD_FREE;
            else
            begin
                case ($urandom_range(2))
                    0:       cmd = CMD_CLOSE;
                    1:       cmd = CMD_INC;
                    default: cmd = CMD_DEC;
                endcase
            end
        end
        roll = $urandom_range(99);
        if (roll < 50)
            iv = VAL_W'($urandom_range(3));
        else if (roll < 70)
            iv = VAL_MAX - VAL_W'($urandom_range(1));
        else
            iv = VAL_W'($urandom());
        push_request(cmd, k, iv);
    endtask

    // Driver: a request stays on the port until taken, then the next follows its gap.
    always @(negedge clk)
    begin : drive_requests
        req_t nxt;
        if (rst_n)
        begin
            if (!start || sent_count == taken_count)
            begin
                if (idle_left > 0)
                begin
                    idle_left <= idle_left - 1;
                    start     <= 1'b0;
                end
                else if (queued_requests.size() > 0)
                begin
                    nxt = queued_requests.pop_front();
                    request    <= nxt;
                    start      <= 1'b1;
                    sent_count <= sent_count + 1;
                    idle_left  <= draw_gap();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each done strobe, then predict any request taken at this edge.
    always @(posedge clk)
    begin : watch_results
        resp_t want;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("done with no request outstanding: status %0d value %0d",
                           result.status, result.current_value);
                    fail_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    status_tally[want.status]++;
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, result.status);
                        fail_count++;
                    end
                    if (result.current_value !== want.current_value)
                    begin
                        $error("current_value: expected %0d, got %0d",
                               want.current_value, result.current_value);
                        fail_count++;
                    end
                end
            end
            if (start && busy === 1'b0)
            begin
                expected_replies.push_back(apply_semaphore_op(request));
                taken_count <= taken_count + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, expected_replies.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            sem_key[i]  = '0;
            sem_cur[i]  = '0;
            sem_max[i]  = '0;
            sem_refs[i] = '0;
        end
        key_pool[0] = {KEY_W{1'b1}};
        key_pool[1] = KEY_W'(1);
        for (int i = 2; i < POOL_SIZE; i++)
        begin
            key_pool[i] = KEY_W'($urandom());
            if (key_pool[i] == '0)
                key_pool[i] = KEY_W'(i);
        end

        // Directed: invalid key and command, absent key, limits of count and value.
        push_request(CMD_OPEN, '0, VAL_W'(5));
        push_request(CMD_DEC, '0, '0);
        push_request(CMD_RSVD_A, KEY_W'(1), VAL_W'(1));
        push_request(CMD_RSVD_B, KEY_W'(1), VAL_W'(1));
        push_request(CMD_RSVD_C, KEY_W'(1), VAL_W'(1));
        push_request(CMD_CLOSE, KEY_W'(1), '0);
        push_request(CMD_FREE, KEY_W'(1), '0);
        push_request(CMD_INC, KEY_W'(1), '0);
        push_request(CMD_DEC, KEY_W'(1), '0);
        push_request(CMD_OPEN, {KEY_W{1'b1}}, VAL_MAX);
        push_request(CMD_INC, {KEY_W{1'b1}}, '0);
        push_request(CMD_DEC, {KEY_W{1'b1}}, '0);
        push_request(CMD_OPEN, KEY_W'(1), '0);
        push_request(CMD_DEC, KEY_W'(1), '0);
        push_request(CMD_INC, KEY_W'(1), '0);
        push_request(CMD_OPEN, KEY_W'(1), VAL_MAX);
        push_request(CMD_CLOSE, KEY_W'(1), '0);
        push_request(CMD_CLOSE, KEY_W'(1), '0);
        // Close with no references left fails; free then still releases the slot.
        push_request(CMD_CLOSE, KEY_W'(1), '0);
        push_request(CMD_FREE, KEY_W'(1), '0);
        push_request(CMD_OPEN, {KEY_W{1'b1}}, VAL_W'(7));
        push_request(CMD_FREE, {KEY_W{1'b1}}, '0);
        push_request(CMD_FREE, {KEY_W{1'b1}}, '0);
        push_request(CMD_OPEN, KEY_W'(2), VAL_W'(1));
        push_request(CMD_DEC, KEY_W'(2), '0);

        // Alternate phases that fill the table past full and phases that drain it.
        for (int seg = 0; seg < 4; seg++)
        begin
            for (int n = 0; n < 150; n++)
            begin
                if (seg % 2 == 0)
                    queue_random_request(55, 10);
                else
                    queue_random_request(15, 40);
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (queued_requests.size() > 0 || start || expected_replies.size() > 0
               || sent_count != taken_count)
            @(negedge clk);
        repeat (NUM_SLOTS + 8) @(negedge clk);

        if (expected_replies.size() != 0 || sent_count != taken_count)
        begin
            $error("run ended with %0d replies outstanding", expected_replies.size());
            fail_count++;
        end

        $display("Checked %0d requests in %0d cycles:", taken_count, cycle_count);
        $display("  %0d ok, %0d not found, %0d full, %0d blocked",
                 status_tally[ST_OK], status_tally[ST_NOTFOUND],
                 status_tally[ST_FULL], status_tally[ST_BLOCK]);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
